FILE: src/zvpt_pkg.sv
`default_nettype none
package zvpt_pkg;

	localparam int FRAC_BITS = 32;
	localparam int WORD_BITS = 40;

	localparam int SPLIT = 32;
	localparam int D_W = ((WORD_BITS > FRAC_BITS + 1) ? WORD_BITS : FRAC_BITS + 1) + 1;
	localparam int HI_W = D_W - SPLIT;
	localparam int SQ_W = 2 * D_W;
	localparam int S_W = 2 * D_W + 2;
	localparam int R_W = D_W + 1;
	localparam int QV_W = S_W - FRAC_BITS;
	localparam int SH = 2 * FRAC_BITS + 1 - 32;
	localparam int Q_W = 33 + SH;
	localparam int T_W = ((Q_W > QV_W) ? Q_W : QV_W) + 2;
	localparam int DIF_W = T_W + 2;
	localparam int CMP_W = WORD_BITS + FRAC_BITS + 32;
	localparam int LANES = 5;
	localparam int LATENCY = 4 + R_W + Q_W + 3;

	localparam int LANE_D1 = 0;
	localparam int LANE_D2 = 1;
	localparam int LANE_X = 2;
	localparam int LANE_Y = 3;
	localparam int LANE_Z = 4;

	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS_RATIO = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;
	localparam logic [CFG_W-1:0] MASS_RATIO_RST = 32'd12898;
	localparam logic [CFG_W-1:0] TOLERANCE_RST = 32'd4295;

	localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};

	typedef struct packed {
		logic signed [WORD_BITS-1:0] pos_x;
		logic signed [WORD_BITS-1:0] pos_y;
		logic signed [WORD_BITS-1:0] pos_z;
		logic signed [WORD_BITS-1:0] jacobi_constant;
	} zvpt_in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] difference;
		logic on_curve;
		logic range_flag;
	} zvpt_out_t;

	typedef struct packed {
		logic [QV_W-1:0] q;
		logic signed [WORD_BITS-1:0] c;
		logic zero;
	} zvpt_side_t;

endpackage
`default_nettype wire

FILE: src/zero_velocity_point_test.sv
`default_nettype none
// zero-velocity point test, restricted three-body problem
// input: pulse start with a point (x, y, z) and a jacobi constant on point;
// a beat is taken at every edge where start is high and busy is low. busy
// stays low, so a new point can enter in every cycle.
// output: done is high for one cycle with result (2U - C, on_curve,
// range_flag). results come out in input order and cannot be held off.
// pipeline: its depth is set by the one bit a stage square roots (R_W
// stages) and the one bit a stage dividers (Q_W stages). throughput is
// one point per cycle.
// configuration: cfg_we with cfg_idx selects mass_ratio (0) or tolerance
// (1); write only with no point in flight.
// reset: arst_n clears all valid bits and loads the default mass ratio and
// tolerance; points in flight are dropped.
module zero_velocity_point_test (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire zvpt_pkg::zvpt_in_t            point,
	output      logic                          done,
	output      zvpt_pkg::zvpt_out_t           result,
	input  wire logic                          cfg_we,
	input  wire logic [zvpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [zvpt_pkg::CFG_W-1:0]    cfg_wdata
);
	import zvpt_pkg::*;

	logic [CFG_W-1:0] mass_ratio_q, tolerance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_ratio_q <= MASS_RATIO_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MASS_RATIO: mass_ratio_q <= cfg_wdata;
				CFG_TOLERANCE: tolerance_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// mu at F fraction bits and the numerators of the two potential terms
	logic [D_W-1:0] mu_f;
	localparam logic [D_W-1:0] ONE = D_W'(1) << FRAC_BITS;
	generate
		if (FRAC_BITS >= 32) begin : g_mu_up
			assign mu_f = D_W'(mass_ratio_q) << (FRAC_BITS - 32);
		end else begin : g_mu_dn
			assign mu_f = D_W'(mass_ratio_q >> (32 - FRAC_BITS));
		end
	endgenerate

	logic [32:0] mu_c;
	logic [Q_W-1:0] num1, num2;
	assign mu_c = 33'h1_0000_0000 - {1'b0, mass_ratio_q};
	assign num1 = Q_W'(mu_c) << SH;
	assign num2 = Q_W'(mass_ratio_q) << SH;

	// stage 1: offsets and magnitudes
	logic signed [D_W:0] xs, e1, e2;
	logic [WORD_BITS-1:0] xm, ym, zm;
	assign xs = (D_W+1)'(point.pos_x);
	assign e1 = xs + $signed({1'b0, mu_f});
	assign e2 = e1 - $signed({1'b0, ONE});
	assign xm = point.pos_x[WORD_BITS-1] ? WORD_BITS'(-point.pos_x) : point.pos_x;
	assign ym = point.pos_y[WORD_BITS-1] ? WORD_BITS'(-point.pos_y) : point.pos_y;
	assign zm = point.pos_z[WORD_BITS-1] ? WORD_BITS'(-point.pos_z) : point.pos_z;

	logic [D_W-1:0] lane_s1 [LANES];
	logic signed [WORD_BITS-1:0] c_s1, c_s2, c_s3, c_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk) begin
		lane_s1[LANE_D1] <= e1[D_W] ? D_W'(-e1) : D_W'(e1);
		lane_s1[LANE_D2] <= e2[D_W] ? D_W'(-e2) : D_W'(e2);
		lane_s1[LANE_X] <= D_W'(xm);
		lane_s1[LANE_Y] <= D_W'(ym);
		lane_s1[LANE_Z] <= D_W'(zm);
		c_s1 <= point.jacobi_constant;
	end

	// stage 2: partial products, stage 3: squares
	logic [2*SPLIT-1:0] ll_s2 [LANES];
	logic [HI_W+SPLIT-1:0] hl_s2 [LANES];
	logic [2*HI_W-1:0] hh_s2 [LANES];
	logic [SQ_W-1:0] sq_s3 [LANES];

	generate
		for (genvar i = 0; i < LANES; i++) begin : g_sq
			always_ff @(posedge clk) begin
				ll_s2[i] <= lane_s1[i][SPLIT-1:0] * lane_s1[i][SPLIT-1:0];
				hl_s2[i] <= lane_s1[i][D_W-1:SPLIT] * lane_s1[i][SPLIT-1:0];
				hh_s2[i] <= lane_s1[i][D_W-1:SPLIT] * lane_s1[i][D_W-1:SPLIT];
				sq_s3[i] <= (SQ_W'(hh_s2[i]) << (2*SPLIT)) + (SQ_W'(hl_s2[i]) << (SPLIT+1))
					+ SQ_W'(ll_s2[i]);
			end
		end
	endgenerate

	// stage 4: squared distances and the centrifugal term
	logic [S_W-1:0] sum1_s4, sum2_s4, qsum;
	logic [QV_W-1:0] q_s4;
	assign qsum = S_W'(sq_s3[LANE_X]) + S_W'(sq_s3[LANE_Y]);

	always_ff @(posedge clk) begin
		c_s2 <= c_s1;
		c_s3 <= c_s2;
		c_s4 <= c_s3;
		sum1_s4 <= S_W'(sq_s3[LANE_D1]) + S_W'(sq_s3[LANE_Y]) + S_W'(sq_s3[LANE_Z]);
		sum2_s4 <= S_W'(sq_s3[LANE_D2]) + S_W'(sq_s3[LANE_Y]) + S_W'(sq_s3[LANE_Z]);
		q_s4 <= qsum[S_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// square roots, one root bit per stage
	logic [S_W-1:0] rt_rem1_s [R_W];
	logic [S_W-1:0] rt_rem2_s [R_W];
	logic [R_W-1:0] rt_root1_s [R_W];
	logic [R_W-1:0] rt_root2_s [R_W];
	zvpt_side_t rt_side_s [R_W];
	logic rt_v_s [R_W];

	generate
		for (genvar k = 0; k < R_W; k++) begin : g_rt
			localparam int B = R_W - 1 - k;
			logic [S_W-1:0] rem1_in, rem2_in, t1, t2;
			logic [R_W-1:0] root1_in, root2_in;
			zvpt_side_t side_in;
			logic v_in;
			if (k == 0) begin : g_first
				assign rem1_in = sum1_s4;
				assign rem2_in = sum2_s4;
				assign root1_in = '0;
				assign root2_in = '0;
				assign side_in.q = q_s4;
				assign side_in.c = c_s4;
				assign side_in.zero = (sum1_s4 == '0) || (sum2_s4 == '0);
				assign v_in = v_s4;
			end else begin : g_next
				assign rem1_in = rt_rem1_s[k-1];
				assign rem2_in = rt_rem2_s[k-1];
				assign root1_in = rt_root1_s[k-1];
				assign root2_in = rt_root2_s[k-1];
				assign side_in = rt_side_s[k-1];
				assign v_in = rt_v_s[k-1];
			end
			assign t1 = (S_W'(root1_in) << (B+1)) | (S_W'(1) << (2*B));
			assign t2 = (S_W'(root2_in) << (B+1)) | (S_W'(1) << (2*B));

			always_ff @(posedge clk) begin
				rt_side_s[k] <= side_in;
				if (rem1_in >= t1) begin
					rt_rem1_s[k] <= rem1_in - t1;
					rt_root1_s[k] <= root1_in | (R_W'(1) << B);
				end else begin
					rt_rem1_s[k] <= rem1_in;
					rt_root1_s[k] <= root1_in;
				end
				if (rem2_in >= t2) begin
					rt_rem2_s[k] <= rem2_in - t2;
					rt_root2_s[k] <= root2_in | (R_W'(1) << B);
				end else begin
					rt_rem2_s[k] <= rem2_in;
					rt_root2_s[k] <= root2_in;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rt_v_s[k] <= 1'b0;
				end else begin
					rt_v_s[k] <= v_in;
				end
			end
		end
	endgenerate

	// restoring division, one quotient bit per stage
	logic [R_W-1:0] dv_rem1_s [Q_W];
	logic [R_W-1:0] dv_rem2_s [Q_W];
	logic [R_W-1:0] dv_den1_s [Q_W];
	logic [R_W-1:0] dv_den2_s [Q_W];
	logic [Q_W-1:0] dv_quo1_s [Q_W];
	logic [Q_W-1:0] dv_quo2_s [Q_W];
	zvpt_side_t dv_side_s [Q_W];
	logic dv_v_s [Q_W];

	generate
		for (genvar k = 0; k < Q_W; k++) begin : g_dv
			localparam int I = Q_W - 1 - k;
			logic [R_W-1:0] rem1_in, rem2_in, den1_in, den2_in;
			logic [Q_W-1:0] quo1_in, quo2_in;
			logic [R_W:0] sh1, sh2;
			zvpt_side_t side_in;
			logic v_in;
			if (k == 0) begin : g_first
				assign rem1_in = '0;
				assign rem2_in = '0;
				assign den1_in = rt_root1_s[R_W-1];
				assign den2_in = rt_root2_s[R_W-1];
				assign quo1_in = '0;
				assign quo2_in = '0;
				assign side_in = rt_side_s[R_W-1];
				assign v_in = rt_v_s[R_W-1];
			end else begin : g_next
				assign rem1_in = dv_rem1_s[k-1];
				assign rem2_in = dv_rem2_s[k-1];
				assign den1_in = dv_den1_s[k-1];
				assign den2_in = dv_den2_s[k-1];
				assign quo1_in = dv_quo1_s[k-1];
				assign quo2_in = dv_quo2_s[k-1];
				assign side_in = dv_side_s[k-1];
				assign v_in = dv_v_s[k-1];
			end
			assign sh1 = {rem1_in, num1[I]};
			assign sh2 = {rem2_in, num2[I]};

			always_ff @(posedge clk) begin
				dv_side_s[k] <= side_in;
				dv_den1_s[k] <= den1_in;
				dv_den2_s[k] <= den2_in;
				if (sh1 >= {1'b0, den1_in}) begin
					dv_rem1_s[k] <= R_W'(sh1 - {1'b0, den1_in});
					dv_quo1_s[k] <= quo1_in | (Q_W'(1) << I);
				end else begin
					dv_rem1_s[k] <= R_W'(sh1);
					dv_quo1_s[k] <= quo1_in;
				end
				if (sh2 >= {1'b0, den2_in}) begin
					dv_rem2_s[k] <= R_W'(sh2 - {1'b0, den2_in});
					dv_quo2_s[k] <= quo2_in | (Q_W'(1) << I);
				end else begin
					dv_rem2_s[k] <= R_W'(sh2);
					dv_quo2_s[k] <= quo2_in;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[k] <= 1'b0;
				end else begin
					dv_v_s[k] <= v_in;
				end
			end
		end
	endgenerate

	// stage 5: total, stage 6: difference and saturation, stage 7: match
	logic [T_W-1:0] tot_s5;
	logic signed [WORD_BITS-1:0] c_s5;
	logic zero_s5, v_s5, v_s6, done_q;
	logic [WORD_BITS-1:0] diff_s6;
	logic range_s6;
	zvpt_out_t result_q;

	zvpt_side_t last_side;
	assign last_side = dv_side_s[Q_W-1];

	logic signed [DIF_W-1:0] dif, maxv_ext;
	logic sat;
	assign dif = $signed({2'b00, tot_s5}) - DIF_W'(c_s5);
	assign maxv_ext = DIF_W'(MAXV);
	assign sat = dif > maxv_ext;

	logic [WORD_BITS-1:0] dm;
	logic match;
	assign dm = diff_s6[WORD_BITS-1] ? WORD_BITS'(-diff_s6) : diff_s6;
	assign match = (CMP_W'(dm) << 32) < (CMP_W'(tolerance_q) << FRAC_BITS);

	always_ff @(posedge clk) begin
		tot_s5 <= T_W'(last_side.q) + T_W'(dv_quo1_s[Q_W-1]) + T_W'(dv_quo2_s[Q_W-1]);
		c_s5 <= last_side.c;
		zero_s5 <= last_side.zero;
		if (zero_s5 || sat) begin
			diff_s6 <= MAXV;
			range_s6 <= 1'b1;
		end else begin
			diff_s6 <= dif[WORD_BITS-1:0];
			range_s6 <= 1'b0;
		end
		result_q.difference <= diff_s6;
		result_q.range_flag <= range_s6;
		result_q.on_curve <= ~range_s6 & match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s5 <= dv_v_s[Q_W-1];
			v_s6 <= v_s5;
			done_q <= v_s6;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

FILE: src/zvpt_checker.sv
`default_nettype none
module zvpt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire zvpt_pkg::zvpt_out_t           result
);
	import zvpt_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted beat");

	a_range_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.range_flag |-> !result.on_curve)
		else $error("on_curve with range_flag");

	a_range_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.range_flag |-> result.difference == $signed(MAXV))
		else $error("range_flag without saturated difference");

endmodule

bind zero_velocity_point_test zvpt_checker u_zvpt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import zvpt_pkg::*;

	class zvp_scoreboard;
		zvpt_out_t pending[$];
		logic [CFG_W-1:0] mass_ratio;
		logic [CFG_W-1:0] tolerance;
		int errors;

		function new();
			mass_ratio = MASS_RATIO_RST;
			tolerance = TOLERANCE_RST;
			errors = 0;
		endfunction

		function logic [127:0] root_floor(logic [127:0] s);
			logic [127:0] r;
			logic [127:0] c;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (128'd1 << b);
				if (c * c <= s) r = c;
			end
			return r;
		endfunction

		function zvpt_out_t potential_gap(zvpt_in_t p);
			zvpt_out_t e;
			logic signed [63:0] d1, d2, xs, ys, zs, cs;
			logic [127:0] m1, m2, mx, my, mz, s1, s2, t1, t2, q, tot;
			logic signed [131:0] dd;
			logic [WORD_BITS:0] dm;
			xs = p.pos_x;
			ys = p.pos_y;
			zs = p.pos_z;
			cs = p.jacobi_constant;
			d1 = xs + $signed({32'd0, mass_ratio});
			d2 = d1 - (64'sd1 <<< FRAC_BITS);
			m1 = d1 < 0 ? -d1 : d1;
			m2 = d2 < 0 ? -d2 : d2;
			mx = xs < 0 ? -xs : xs;
			my = ys < 0 ? -ys : ys;
			mz = zs < 0 ? -zs : zs;
			s1 = m1 * m1 + my * my + mz * mz;
			s2 = m2 * m2 + my * my + mz * mz;
			e.difference = MAXV;
			e.on_curve = 1'b0;
			e.range_flag = 1'b1;
			if (s1 != 0 && s2 != 0) begin
				t1 = ((128'd1 << 32) - mass_ratio) << SH;
				t1 = t1 / root_floor(s1);
				t2 = (128'(mass_ratio) << SH) / root_floor(s2);
				q = (mx * mx + my * my) >> FRAC_BITS;
				tot = q + t1 + t2;
				dd = $signed({4'd0, tot}) - cs;
				if (dd <= $signed({1'b0, MAXV})) begin
					e.difference = dd[WORD_BITS-1:0];
					e.range_flag = 1'b0;
					dm = e.difference < 0 ? -$signed({e.difference[WORD_BITS-1], e.difference})
						: {1'b0, e.difference};
					e.on_curve = dm < tolerance;
				end
			end
			return e;
		endfunction

		function void note_point(zvpt_in_t p);
			pending.insert(pending.size(), potential_gap(p));
		endfunction

		function void check_result(zvpt_out_t r);
			zvpt_out_t e;
			if (pending.size() == 0) begin
				$error("result with no beat pending: %h", r);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.difference !== e.difference) begin
				$error("difference: expected %0d actual %0d", e.difference, r.difference);
				errors++;
			end
			if (r.on_curve !== e.on_curve) begin
				$error("on_curve: expected %b actual %b", e.on_curve, r.on_curve);
				errors++;
			end
			if (r.range_flag !== e.range_flag) begin
				$error("range_flag: expected %b actual %b", e.range_flag, r.range_flag);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	zvpt_in_t point = '0;
	logic done;
	zvpt_out_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_MASS_RATIO;
	logic [CFG_W-1:0] cfg_wdata = '0;
	zvp_scoreboard sb = new();
	int unsigned cycles = 0;
	int unsigned sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	zero_velocity_point_test dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("[zero_velocity_point_test] ERROR");
			$finish;
		end
	end

	task automatic send_point(zvpt_in_t p, bit gaps);
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		sb.note_point(p);
		sent++;
		if (gaps && $urandom_range(99) < 4) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MASS_RATIO) sb.mass_ratio = v;
		else sb.tolerance = v;
	endtask

	function automatic logic signed [WORD_BITS-1:0] near_word(int unsigned span);
		logic signed [63:0] v;
		v = $signed({32'd0, $urandom()}) + ($signed({32'd0, $urandom_range(span)}) <<< 32);
		if ($urandom_range(1)) v = -v;
		return v[WORD_BITS-1:0];
	endfunction

	function automatic logic signed [WORD_BITS-1:0] full_word();
		return WORD_BITS'({$urandom(), $urandom()});
	endfunction

	function automatic zvpt_in_t random_point();
		zvpt_in_t p;
		zvpt_out_t e;
		if ($urandom_range(99) < 75) begin
			p.pos_x = near_word(2);
			p.pos_y = near_word(1);
			p.pos_z = $urandom_range(3) == 0 ? '0 : near_word(1);
			p.jacobi_constant = near_word(7);
			if ($urandom_range(3) == 0) begin
				p.jacobi_constant = '0;
				e = sb.potential_gap(p);
				p.jacobi_constant = e.difference + $signed(40'($urandom_range(8))) - 4;
			end
		end else begin
			p = {full_word(), full_word(), full_word(), full_word()};
		end
		return p;
	endfunction

	task automatic directed_set();
		zvpt_in_t p;
		zvpt_out_t e;
		logic signed [WORD_BITS-1:0] mu;
		mu = {8'd0, sb.mass_ratio};
		p = '0;
		p.pos_x = -mu;
		send_point(p, 0);
		p.pos_x = (40'sd1 <<< 32) - mu;
		send_point(p, 0);
		p.pos_z = 40'sd1;
		send_point(p, 0);
		p = {MAXV, MAXV, MAXV, MAXV};
		send_point(p, 0);
		p = {~MAXV, ~MAXV, ~MAXV, ~MAXV};
		send_point(p, 0);
		p = {~MAXV, 40'sd0, 40'sd0, MAXV};
		send_point(p, 0);
		p = {40'sd1 <<< 31, 40'sd1 <<< 32, -40'sd1, 40'sd0};
		send_point(p, 0);
		e = sb.potential_gap(p);
		p.jacobi_constant = e.difference;
		send_point(p, 0);
		p.jacobi_constant = e.difference + 1;
		send_point(p, 0);
		p.jacobi_constant = e.difference - $signed({8'd0, sb.tolerance});
		send_point(p, 0);
		p.jacobi_constant = ~MAXV;
		send_point(p, 0);
	endtask

	initial begin
		logic [CFG_W-1:0] mus[6];
		logic [CFG_W-1:0] tols[6];
		mus = '{MASS_RATIO_RST, 32'd0, 32'h8000_0000, 32'hffff_ffff, 32'd1, $urandom()};
		tols = '{TOLERANCE_RST, 32'hffff_ffff, 32'd0, 32'd1, $urandom(), 32'h0100_0000};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_set();
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(CFG_MASS_RATIO, mus[ph]);
				write_reg(CFG_TOLERANCE, tols[ph]);
				directed_set();
			end
			for (int i = 0; i < 170; i++)
				send_point(random_point(), !(ph == 2 && i >= 20 && i < 150));
			drain();
		end
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[zero_velocity_point_test] OK");
		else
			$display("[zero_velocity_point_test] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
